@@ rtl/b64se_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 stream encoder package
// Shared item types, group descriptor and the base64 alphabet mapping.
// ----------------------------------------------------------------------------
package b64se_pkg;

  localparam logic [7:0] PadChar     = 8'h3D;
  localparam logic [7:0] PlusChar    = 8'h2B;
  localparam logic [7:0] SlashChar   = 8'h2F;
  localparam logic [7:0] UpperBase   = 8'h41;
  localparam logic [7:0] LowerBase   = 8'h61;
  localparam logic [7:0] DigitBase   = 8'h30;
  localparam logic [5:0] LowerStart  = 6'd26;
  localparam logic [5:0] DigitStart  = 6'd52;
  localparam logic [5:0] PlusIndex   = 6'd62;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } b64se_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } b64se_out_t;

  // One group of up to three bytes waiting to be turned into characters.
  typedef struct packed {
    logic [23:0] group;
    logic [1:0]  npad;
    logic        is_final;
  } b64se_grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64se_q_status_t;

  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] wide;
    wide = {2'b00, idx};
    if (idx < LowerStart) begin
      return UpperBase + wide;
    end else if (idx < DigitStart) begin
      return LowerBase + wide - {2'b00, LowerStart};
    end else if (idx < PlusIndex) begin
      return DigitBase + wide - {2'b00, DigitStart};
    end else if (idx == PlusIndex) begin
      return PlusChar;
    end else begin
      return SlashChar;
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/b64se_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Accepts bytes, gathers them into groups of three, or fewer at the final byte, and pushes each group.
// ----------------------------------------------------------------------------
module b64se_front (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  b64se_pkg::b64se_in_t      in_item_i,
  input  b64se_pkg::b64se_q_status_t q_status_i,
  output logic                      push_o,
  output b64se_pkg::b64se_grp_t     push_grp_o
);
  import b64se_pkg::*;

  logic [15:0] bytes_q, bytes_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        accept;

  assign in_ready_o = ~q_status_i.full;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    bytes_d             = bytes_q;
    cnt_d               = cnt_q;
    push_o              = 1'b0;
    push_grp_o.group    = {bytes_q, in_item_i.data_byte};
    push_grp_o.npad     = 2'd0;
    push_grp_o.is_final = in_item_i.final_byte;
    if (accept) begin
      case (cnt_q)
        2'd2: begin
          push_o  = 1'b1;
          bytes_d = 16'd0;
          cnt_d   = 2'd0;
        end
        2'd1: begin
          if (in_item_i.final_byte) begin
            push_o           = 1'b1;
            push_grp_o.group = {bytes_q[7:0], in_item_i.data_byte, 8'd0};
            push_grp_o.npad  = 2'd1;
            bytes_d          = 16'd0;
            cnt_d            = 2'd0;
          end else begin
            bytes_d = {bytes_q[7:0], in_item_i.data_byte};
            cnt_d   = 2'd2;
          end
        end
        default: begin
          // An empty group; a count of three cannot arise and is taken as empty.
          if (in_item_i.final_byte) begin
            push_o           = 1'b1;
            push_grp_o.group = {in_item_i.data_byte, 16'd0};
            push_grp_o.npad  = 2'd2;
            bytes_d          = 16'd0;
            cnt_d            = 2'd0;
          end else begin
            bytes_d = {bytes_q[7:0], in_item_i.data_byte};
            cnt_d   = 2'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q <= 16'd0;
      cnt_q   <= 2'd0;
    end else begin
      bytes_q <= bytes_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/b64se_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 encoder group queue
// Small register FIFO of group descriptors between front and back end.
// ----------------------------------------------------------------------------
module b64se_queue #(
  parameter int Depth = 2
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        push_i,
  input  b64se_pkg::b64se_grp_t      push_grp_i,
  input  wire                        pop_i,
  output b64se_pkg::b64se_grp_t      pop_grp_o,
  output b64se_pkg::b64se_q_status_t status_o
);
  import b64se_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  b64se_grp_t          mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i & ~status_o.full;
  assign do_pop         = pop_i & ~status_o.empty;
  assign pop_grp_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/b64se_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Takes one group at a time and sends out its four characters in turn.
// ----------------------------------------------------------------------------
module b64se_back (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  b64se_pkg::b64se_q_status_t q_status_i,
  input  b64se_pkg::b64se_grp_t      pop_grp_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output b64se_pkg::b64se_out_t      out_item_o
);
  import b64se_pkg::*;

  b64se_grp_t grp_q;
  logic [1:0] pos_q;
  logic       busy_q;
  logic       out_done;
  logic       grp_done;
  logic [5:0] sextet;
  logic [2:0] pad_sum;

  assign out_valid_o = busy_q;
  assign out_done    = busy_q & out_ready_i;
  assign grp_done    = out_done & (pos_q == 2'd3);
  assign pop_o       = ~q_status_i.empty & (~busy_q | grp_done);

  always_comb begin
    case (pos_q)
      2'd0:    sextet = grp_q.group[23:18];
      2'd1:    sextet = grp_q.group[17:12];
      2'd2:    sextet = grp_q.group[11:6];
      default: sextet = grp_q.group[5:0];
    endcase
    // Positions at or beyond four minus the pad count are pad characters.
    pad_sum              = {1'b0, pos_q} + {1'b0, grp_q.npad};
    out_item_o.out_char  = pad_sum[2] ? PadChar : b64_char(sextet);
    out_item_o.last_char = grp_q.is_final & (pos_q == 2'd3);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      grp_q <= pop_grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= 2'd0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        pos_q  <= 2'd0;
      end else if (grp_done) begin
        busy_q <= 1'b0;
        pos_q  <= 2'd0;
      end else if (out_done) begin
        pos_q <= pos_q + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/base64_stream_encoder.sv @@
`default_nettype none
// A byte that closes a group is written into the queue and then loaded into the
// back end's group register before its first character shows.
// Throughput: one byte a cycle into the front end while the queue is not full;
// the back end's serialiser sends one character a cycle while out_ready_i is high.
// Reset: asynchronous, active low; clears held bytes, queue pointers and
// serialiser state, and no clearing pass is needed.
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Encodes a byte stream into padded standard base64 characters.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
  parameter int QueueDepth = 2
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  b64se_pkg::b64se_in_t  in_item_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output b64se_pkg::b64se_out_t out_item_o
);
  import b64se_pkg::*;

  // The front end holds up to two bytes of an unfinished group. When a third
  // byte arrives, or the final byte of the message, it builds a group
  // descriptor: the 24-bit group, how many trailing characters are padding
  // and whether the group ends the message.
  logic            push;
  b64se_grp_t      push_grp;
  b64se_grp_t      pop_grp;
  logic            pop;
  b64se_q_status_t q_status;

  b64se_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_status_i (q_status),
    .push_o     (push),
    .push_grp_o (push_grp)
  );

  // The queue decouples the two sides, so bytes keep being taken while the
  // back end is still sending out the characters of an earlier group.
  b64se_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_grp_i (push_grp),
    .pop_i      (pop),
    .pop_grp_o  (pop_grp),
    .status_o   (q_status)
  );

  // The back end turns each group into four characters, one item at a time,
  // and takes the next group, if one is waiting, in the same cycle as the last character leaves.
  b64se_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .pop_grp_i   (pop_grp),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire
